// ----- rtl/software_timer_bank_top_macros.svh -----
// assertion macros for the timer bank checker
`ifndef SOFTWARE_TIMER_BANK_TOP_MACROS_SVH
`define SOFTWARE_TIMER_BANK_TOP_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define TSB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer bank port check failed");

// antecedent holds, consequent holds in the next cycle
`define TSB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer bank port check failed");

`endif

// ----- rtl/tsb_pkg.sv -----
// ----------------------------------------------------------------------------
// tsb_pkg
// types, codes and constants shared by the timer bank modules
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int NUM_SLOTS_DEF = 32;
  localparam int MAX_RESULTS   = 32;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  // request operation codes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_START  = 3'd3;
  localparam logic [2:0] OP_STOP   = 3'd4;

  // result event codes
  localparam logic [2:0] EV_FIRED   = 3'd0;
  localparam logic [2:0] EV_NOFIRE  = 3'd1;
  localparam logic [2:0] EV_ADDED   = 3'd2;
  localparam logic [2:0] EV_FULL    = 3'd3;
  localparam logic [2:0] EV_DELETED = 3'd4;
  localparam logic [2:0] EV_NOTUSED = 3'd5;
  localparam logic [2:0] EV_ACK     = 3'd6;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] period;
    logic [15:0] repeat_total;
    logic [15:0] action_tag;
    logic [4:0]  target_slot;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [4:0]  slot;
    logic [15:0] tag_out;
    logic        expired;
    logic        last;
  } res_t;

  // one timer slot as it travels round the ring
  typedef struct packed {
    logic        used;
    logic [31:0] period;
    logic [31:0] remaining;
    logic [15:0] repeats;
    logic [15:0] tag;
  } slot_t;

  typedef enum logic [1:0] {
    WALK_TICK,
    WALK_ADD,
    WALK_DEL,
    WALK_STOP
  } walk_t;

  typedef struct packed {
    walk_t       mode;
    logic        add_free;
    logic        del_hit;
    logic [31:0] period;
    logic [15:0] repeat_total;
    logic [15:0] action_tag;
  } proc_ctl_t;

  typedef struct packed {
    logic        fire;
    logic        expired;
    logic [15:0] tag;
    logic        claim;
    logic        hit;
  } proc_stat_t;

endpackage

// ----- rtl/tsb_cell.sv -----
// ----------------------------------------------------------------------------
// tsb_cell
// one ring cell holding a timer slot, loads its neighbor on each shift
// ----------------------------------------------------------------------------
module tsb_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  tsb_pkg::slot_t d,
  output tsb_pkg::slot_t q
);
  import tsb_pkg::*;

  logic        used;
  logic [31:0] period;
  logic [31:0] remaining;
  logic [15:0] repeats;
  logic [15:0] tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (shift) begin
      used <= d.used;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      period    <= d.period;
      remaining <= d.remaining;
      repeats   <= d.repeats;
      tag       <= d.tag;
    end
  end

  assign q = '{used: used, period: period, remaining: remaining,
               repeats: repeats, tag: tag};

endmodule

// ----- rtl/tsb_proc.sv -----
// ----------------------------------------------------------------------------
// tsb_proc
// updates the slot at the head of the ring before it re-enters the tail
// ----------------------------------------------------------------------------
module tsb_proc (
  input  tsb_pkg::slot_t     cur,
  input  tsb_pkg::proc_ctl_t ctl,
  output tsb_pkg::slot_t     nxt,
  output tsb_pkg::proc_stat_t stat
);
  import tsb_pkg::*;

  logic [31:0] rem_dec;

  assign rem_dec = cur.remaining - 32'd1;

  always_comb begin
    nxt  = cur;
    stat = '0;
    unique case (ctl.mode)
      WALK_TICK: begin
        if (cur.used) begin
          if (rem_dec == 32'd0) begin
            nxt.remaining = cur.period;
            stat.fire     = 1'b1;
            stat.tag      = cur.tag;
            if (cur.repeats != 16'd0) begin
              nxt.repeats = cur.repeats - 16'd1;
              // last repeat used up: slot goes free
              if (cur.repeats == 16'd1) begin
                nxt.used     = 1'b0;
                stat.expired = 1'b1;
              end
            end
          end else begin
            nxt.remaining = rem_dec;
          end
        end
      end
      WALK_ADD: begin
        if (ctl.add_free && !cur.used) begin
          nxt.used      = 1'b1;
          nxt.period    = ctl.period;
          nxt.remaining = ctl.period;
          nxt.repeats   = ctl.repeat_total;
          nxt.tag       = ctl.action_tag;
          stat.claim    = 1'b1;
        end
      end
      WALK_DEL: begin
        if (ctl.del_hit && cur.used) begin
          nxt.used      = 1'b0;
          nxt.period    = 32'd0;
          nxt.remaining = 32'd0;
          stat.hit      = 1'b1;
        end
      end
      WALK_STOP: begin
        if (cur.used) begin
          nxt.remaining = 32'd0;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ----- rtl/tsb_seq.sv -----
// ----------------------------------------------------------------------------
// tsb_seq
// request sequencer: steps the ring once around and forms the results
// ----------------------------------------------------------------------------
module tsb_seq #(
  parameter int NUM_SLOTS = tsb_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  tsb_pkg::req_t       req,
  input  tsb_pkg::proc_stat_t stat,
  output logic                shift,
  output tsb_pkg::proc_ctl_t  ctl,
  output logic                strobe,
  output tsb_pkg::res_t       res
);
  import tsb_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t           state;
  logic             running;
  walk_t            mode;
  logic [31:0]      per_q;
  logic [15:0]      rep_q;
  logic [15:0]      tag_q;
  logic [4:0]       tgt_q;
  logic [IDX_W-1:0] idx;
  logic             found;
  logic [4:0]       found_slot;
  logic             del_ok;
  logic             pend_valid;
  res_t             pend;
  logic [CNT_W-1:0] cnt;
  logic [6:0]       idx_wide;
  logic [4:0]       idx_slot;

  assign idx_wide = 7'(idx);
  assign idx_slot = idx_wide[4:0];

  assign busy  = (state != S_IDLE);
  assign shift = (state == S_WALK);

  always_comb begin
    ctl.mode         = mode;
    ctl.add_free     = !found;
    ctl.del_hit      = (idx_wide == 7'(tgt_q));
    ctl.period       = per_q;
    ctl.repeat_total = rep_q;
    ctl.action_tag   = tag_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      running    <= 1'b0;
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
      del_ok     <= 1'b0;
      idx        <= '0;
      cnt        <= '0;
      mode       <= WALK_TICK;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            per_q      <= req.period;
            rep_q      <= req.repeat_total;
            tag_q      <= req.action_tag;
            tgt_q      <= req.target_slot;
            idx        <= '0;
            found      <= 1'b0;
            del_ok     <= 1'b0;
            pend_valid <= 1'b0;
            cnt        <= '0;
            unique case (req.operation)
              OP_TICK: begin
                if (running) begin
                  mode  <= WALK_TICK;
                  state <= S_WALK;
                end else begin
                  strobe <= 1'b1;
                  res    <= '{EV_NOFIRE, 5'd0, 16'd0, 1'b0, 1'b1};
                end
              end
              OP_ADD: begin
                mode  <= WALK_ADD;
                state <= S_WALK;
              end
              OP_DELETE: begin
                mode  <= WALK_DEL;
                state <= S_WALK;
              end
              OP_START: begin
                running <= 1'b1;
                strobe  <= 1'b1;
                res     <= '{EV_ACK, 5'd0, 16'd0, 1'b0, 1'b1};
              end
              OP_STOP: begin
                running <= 1'b0;
                mode    <= WALK_STOP;
                state   <= S_WALK;
              end
              default: begin
                strobe <= 1'b1;
                res    <= '{EV_ACK, 5'd0, 16'd0, 1'b0, 1'b1};
              end
            endcase
          end
        end
        S_WALK: begin
          if (stat.claim) begin
            found      <= 1'b1;
            found_slot <= idx_slot;
          end
          if (stat.hit) begin
            del_ok <= 1'b1;
          end
          // hold one firing back so the final one can carry last
          if (stat.fire && (cnt < CNT_W'(MAX_RESULTS))) begin
            pend       <= '{EV_FIRED, idx_slot, stat.tag, stat.expired, 1'b0};
            pend_valid <= 1'b1;
            cnt        <= cnt + CNT_W'(1);
            if (pend_valid) begin
              strobe <= 1'b1;
              res    <= pend;
            end
          end
          if (idx == IDX_LAST) begin
            idx   <= '0;
            state <= S_DONE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DONE: begin
          state  <= S_IDLE;
          strobe <= 1'b1;
          unique case (mode)
            WALK_TICK: begin
              if (pend_valid) begin
                res <= '{pend.event_res, pend.slot, pend.tag_out, pend.expired, 1'b1};
              end else begin
                res <= '{EV_NOFIRE, 5'd0, 16'd0, 1'b0, 1'b1};
              end
            end
            WALK_ADD: begin
              if (found) begin
                res <= '{EV_ADDED, found_slot, 16'd0, 1'b0, 1'b1};
              end else begin
                res <= '{EV_FULL, 5'd0, 16'd0, 1'b0, 1'b1};
              end
            end
            WALK_DEL: begin
              if (del_ok) begin
                res <= '{EV_DELETED, tgt_q, 16'd0, 1'b0, 1'b1};
              end else begin
                res <= '{EV_NOTUSED, tgt_q, 16'd0, 1'b0, 1'b1};
              end
            end
            WALK_STOP: begin
              res <= '{EV_ACK, 5'd0, 16'd0, 1'b0, 1'b1};
            end
            default: begin
              res <= '{EV_ACK, 5'd0, 16'd0, 1'b0, 1'b1};
            end
          endcase
          pend_valid <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/software_timer_bank_top.sv -----
// ----------------------------------------------------------------------------
// software_timer_bank_top
// bank of periodic timer slots kept in a rotating ring of cells
// ----------------------------------------------------------------------------
//  channel   | handshake         | payload | direction
//  ----------+-------------------+---------+----------
//  request   | start / busy      | req     | in
//  result    | strobe            | res     | out
//
//  tick while running, add, delete and stop: busy while the ring turns once
//    past the update cell, slot by slot, and then through the closing state
//    that forms the closing result; firings come out while the ring turns
//  tick while stopped, start and unknown operations: result in the next
//    cycle, busy stays low
//  reset is synchronous: clears the used bits, the running flag and the
//    sequencer; slot payload is left as is
//  each result shows for one cycle only, the receiver cannot hold it off
// ----------------------------------------------------------------------------
module software_timer_bank_top #(
  parameter int NUM_SLOTS = tsb_pkg::NUM_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tsb_pkg::req_t  req,
  output logic           strobe,
  output tsb_pkg::res_t  res
);
  import tsb_pkg::*;

  // ring of slot cells, cell 0 is the head that passes through the update
  slot_t      ring_q [NUM_SLOTS];
  slot_t      ring_d [NUM_SLOTS];
  slot_t      head_next;
  logic       shift;
  proc_ctl_t  ctl;
  proc_stat_t stat;

  // sequencer: takes the request, turns the ring, forms results
  tsb_seq #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .stat  (stat),
    .shift (shift),
    .ctl   (ctl),
    .strobe(strobe),
    .res   (res)
  );

  // update cell sitting between head and tail of the ring
  tsb_proc u_proc (
    .cur (ring_q[0]),
    .ctl (ctl),
    .nxt (head_next),
    .stat(stat)
  );

  // each cell takes its upper neighbor, the tail takes the updated head
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_ring
    if (k == NUM_SLOTS - 1) begin : g_tail
      assign ring_d[k] = head_next;
    end else begin : g_mid
      assign ring_d[k] = ring_q[k+1];
    end
    tsb_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(shift),
      .d    (ring_d[k]),
      .q    (ring_q[k])
    );
  end

endmodule

// ----- rtl/tsb_checker.sv -----
// ----------------------------------------------------------------------------
// tsb_checker
// port level checks on the timer bank request and result channels
// ----------------------------------------------------------------------------
`include "software_timer_bank_top_macros.svh"

module tsb_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  logic          strobe,
  input  tsb_pkg::res_t res
);
  import tsb_pkg::*;

  // an accepted request either answers next cycle or holds busy
  `TSB_ASSERT_NEXT(a_accept_acts, start && !busy, strobe || busy)

  // a result without last means more results of the same request follow
  `TSB_ASSERT_NEXT(a_more_follow, strobe && !res.last, busy || strobe)

  // leaving busy always delivers the closing result
  `TSB_ASSERT_SAME(a_end_result, $fell(busy), strobe && res.last)

  // no result appears unless a request was taken or one is in progress
  `TSB_ASSERT_NEXT(a_no_spurious, !busy && !start, !strobe)

endmodule

bind software_timer_bank_top tsb_checker u_tsb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .strobe(strobe),
  .res   (res)
);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the timer bank: requests go in over start/busy,
// an in-bench copy of the slot table works out every event that a request
// must produce, and a checker compares each strobed result with the oldest
// pending event
// ----------------------------------------------------------------------------
module testbench;
  import tsb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 400;
  localparam int CALM_TAIL     = 80;   // last random requests go without gaps
  localparam int SETTLE_CYCLES = 40;   // a bit more than one ring turn

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic strobe;
  res_t res;

  // expected events in arrival order
  res_t pending_events [$];

  // in-bench copy of the slot table
  bit        occupied     [NUM_SLOTS_DEF];
  bit [31:0] reload_ticks [NUM_SLOTS_DEF];
  bit [31:0] countdown    [NUM_SLOTS_DEF];
  bit [15:0] fires_left   [NUM_SLOTS_DEF];
  bit [15:0] timer_tag    [NUM_SLOTS_DEF];
  bit        counting;

  int cycle_count    = 0;
  int mismatch_count = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int firings_seen   = 0;
  int expiries_seen  = 0;
  int full_seen      = 0;

  always #4 clk = ~clk;

  software_timer_bank_top #(
    .NUM_SLOTS(NUM_SLOTS_DEF)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .strobe(strobe),
    .res   (res)
  );

  // --------------------------------------------------------------------------
  // event prediction
  // --------------------------------------------------------------------------
  function automatic res_t make_event(logic [2:0] code, logic [4:0] idx,
                                      logic [15:0] tag, logic gone);
    res_t ev;
    ev           = '0;
    ev.event_res = code;
    ev.slot      = idx;
    ev.tag_out   = tag;
    ev.expired   = gone;
    return ev;
  endfunction

  // freeing clears the stored period and the running count
  task automatic free_timer(input int idx);
    occupied[idx]     = 1'b0;
    reload_ticks[idx] = '0;
    countdown[idx]    = '0;
  endtask

  // apply one accepted request to the table copy and queue its events
  task automatic advance_bank(input req_t r);
    res_t batch [MAX_RESULTS];
    int   n;
    int   i;
    n = 0;
    case (r.operation)
      OP_TICK: begin
        if (counting) begin
          // every used slot counts down, firing slots report in index order
          for (i = 0; i < NUM_SLOTS_DEF; i++) begin
            if (occupied[i]) begin
              countdown[i] = countdown[i] - 32'd1;
              if (countdown[i] == 32'd0) begin
                countdown[i] = reload_ticks[i];
                batch[n] = make_event(EV_FIRED, i[4:0], timer_tag[i], 1'b0);
                // zero repeats means forever
                if (fires_left[i] != 16'd0) begin
                  fires_left[i] = fires_left[i] - 16'd1;
                  if (fires_left[i] == 16'd0) begin
                    free_timer(i);
                    batch[n].expired = 1'b1;
                  end
                end
                if (n < MAX_RESULTS) n++;
              end
            end
          end
        end
        if (n == 0) begin
          batch[0] = make_event(EV_NOFIRE, '0, '0, 1'b0);
          n = 1;
        end
      end
      OP_ADD: begin
        // lowest free slot wins
        i = 0;
        while (i < NUM_SLOTS_DEF && occupied[i]) i++;
        if (i < NUM_SLOTS_DEF) begin
          occupied[i]     = 1'b1;
          reload_ticks[i] = r.period;
          countdown[i]    = r.period;
          fires_left[i]   = r.repeat_total;
          timer_tag[i]    = r.action_tag;
          batch[0] = make_event(EV_ADDED, i[4:0], '0, 1'b0);
        end else begin
          batch[0] = make_event(EV_FULL, '0, '0, 1'b0);
        end
        n = 1;
      end
      OP_DELETE: begin
        if (occupied[r.target_slot]) begin
          free_timer(int'(r.target_slot));
          batch[0] = make_event(EV_DELETED, r.target_slot, '0, 1'b0);
        end else begin
          batch[0] = make_event(EV_NOTUSED, r.target_slot, '0, 1'b0);
        end
        n = 1;
      end
      OP_START: begin
        counting = 1'b1;
        batch[0] = make_event(EV_ACK, '0, '0, 1'b0);
        n = 1;
      end
      OP_STOP: begin
        // stopped counts sit at zero and wrap on the next decrement
        counting = 1'b0;
        for (i = 0; i < NUM_SLOTS_DEF; i++)
          if (occupied[i]) countdown[i] = '0;
        batch[0] = make_event(EV_ACK, '0, '0, 1'b0);
        n = 1;
      end
      default: begin
        // spare opcodes only get an ack
        batch[0] = make_event(EV_ACK, '0, '0, 1'b0);
        n = 1;
      end
    endcase
    batch[n-1].last = 1'b1;
    for (i = 0; i < n; i++) pending_events.push_back(batch[i]);
  endtask

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  // start stays high after acceptance, so a following request goes out
  // back to back; a gap or a drain lowers it
  task automatic send_request(input req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy !== 1'b0);
    advance_bank(r);
    requests_sent++;
  endtask

  task automatic pause_requests(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every pending event has come back
  task automatic hold_until_drained();
    start <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  function automatic req_t make_request(logic [2:0] op, logic [31:0] per,
                                        logic [15:0] reps, logic [15:0] tag,
                                        logic [4:0] tgt);
    req_t r;
    r.operation    = op;
    r.period       = per;
    r.repeat_total = reps;
    r.action_tag   = tag;
    r.target_slot  = tgt;
    return r;
  endfunction

  // request with every unused field filled with noise
  function automatic req_t noisy_request(logic [2:0] op);
    return make_request(op, $urandom, 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
  endfunction

  function automatic int used_count();
    int cnt;
    cnt = 0;
    foreach (occupied[i]) cnt += int'(occupied[i]);
    return cnt;
  endfunction

  // mostly short live timers so that firings and expiries happen often
  function automatic req_t random_request();
    req_t r;
    int   w;
    int   pick;
    r = noisy_request(OP_TICK);
    w = $urandom_range(0, 99);
    if (w < 45)      r.operation = OP_TICK;
    else if (w < 70) r.operation = OP_ADD;
    else if (w < 85) r.operation = OP_DELETE;
    else if (w < 91) r.operation = OP_START;
    else if (w < 95) r.operation = OP_STOP;
    else             r.operation = 3'($urandom_range(OP_STOP + 1, 7));
    // a stopped bank gets restarted soon so most ticks actually count
    if (!counting && $urandom_range(0, 1) == 0) r.operation = OP_START;
    case (r.operation)
      OP_ADD: begin
        case ($urandom_range(0, 19))
          0:       r.period = '0;
          1:       r.period = '1;
          2, 3:    r.period = $urandom;
          default: r.period = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 9))
          0:       r.repeat_total = 16'($urandom_range(0, 65535));
          1:       r.repeat_total = '1;
          default: r.repeat_total = 16'($urandom_range(0, 4));
        endcase
      end
      OP_DELETE: begin
        // mostly hit a live slot, now and then a random index
        if (used_count() != 0 && $urandom_range(0, 4) != 0) begin
          do pick = $urandom_range(0, NUM_SLOTS_DEF - 1); while (!occupied[pick]);
          r.target_slot = pick[4:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // result checker: the receiver cannot stall, every strobe is taken
  // --------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && strobe === 1'b1) begin
      results_seen++;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, res);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", 32'(want.event_res), 32'(res.event_res));
        check_field("slot", 32'(want.slot), 32'(res.slot));
        check_field("tag_out", 32'(want.tag_out), 32'(res.tag_out));
        check_field("expired", 32'(want.expired), 32'(res.expired));
        check_field("last", 32'(want.last), 32'(res.last));
        if (want.event_res == EV_FIRED) firings_seen++;
        if (want.expired) expiries_seen++;
        if (want.event_res == EV_FULL) full_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // empty bank: ticks while stopped and running, start and stop twice,
  // deletes of unused slots at both ends, spare opcodes
  task automatic test_quiet_bank();
    send_request(noisy_request(OP_TICK));
    send_request(noisy_request(OP_STOP));
    send_request(make_request(OP_DELETE, '0, '0, '0, 5'd0));
    send_request(make_request(OP_DELETE, '1, '1, '1, 5'd31));
    for (int op = OP_STOP + 1; op < 8; op++) send_request(noisy_request(3'(op)));
    send_request(noisy_request(OP_START));
    send_request(noisy_request(OP_START));
    send_request(noisy_request(OP_TICK));
    send_request(noisy_request(OP_STOP));
  endtask

  // period one, two, zero and all ones; repeats forever, two, max and one;
  // repeat expiry, double delete, stop then start wrap-around
  task automatic test_timer_basics();
    send_request(noisy_request(OP_START));
    send_request(make_request(OP_ADD, 32'd1, 16'd0, 16'hFFFF, 5'd0));
    send_request(make_request(OP_ADD, 32'd2, 16'd2, 16'h0000, 5'd31));
    send_request(make_request(OP_ADD, 32'd0, 16'hFFFF, 16'h5A5A, 5'd7));
    send_request(make_request(OP_ADD, '1, 16'd1, 16'h1234, 5'd0));
    repeat (4) send_request(noisy_request(OP_TICK));
    send_request(make_request(OP_DELETE, $urandom, '0, '0, 5'd3));
    send_request(make_request(OP_DELETE, $urandom, '0, '0, 5'd3));
    send_request(noisy_request(OP_STOP));
    send_request(noisy_request(OP_TICK));
    send_request(noisy_request(OP_START));
    send_request(noisy_request(OP_TICK));
    send_request(make_request(OP_DELETE, '0, '0, '0, 5'd0));
    send_request(make_request(OP_DELETE, '0, '0, '0, 5'd2));
    hold_until_drained();
  endtask

  // fill every slot with one-shot period-one timers, overflow by one,
  // then a single tick fires and frees all of them at once
  task automatic test_full_table();
    send_request(noisy_request(OP_START));
    for (int s = 0; s <= NUM_SLOTS_DEF; s++)
      send_request(make_request(OP_ADD, 32'd1, 16'd1, 16'(s) ^ 16'hA5A5, 5'(s)));
    send_request(noisy_request(OP_TICK));
    send_request(noisy_request(OP_TICK));
  endtask

  // mixed traffic with random gaps, one full drain halfway through,
  // and a gap-free stretch at the end
  task automatic test_random_traffic();
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      send_request(random_request());
      if (k == RANDOM_ITEMS / 2)
        hold_until_drained();
      else if (k < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
        pause_requests($urandom_range(1, 9));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_quiet_bank();
    test_timer_basics();
    test_full_table();
    test_random_traffic();

    // let the last events come back, then watch for strays
    start <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results: %0d firings, %0d expiries,",
             requests_sent, results_seen, firings_seen, expiries_seen);
    $display("%0d table-full replies, %0d mismatches", full_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
